FILE: design/bafq_pkg.sv
`timescale 1ns / 1ps
package bafq_pkg;

    localparam int DEF_FREE_DEPTH = 64;
    localparam int DEF_ADDR_BITS  = 32;

    localparam int FIELD_W    = 32;
    localparam int LOG2_W     = 5;
    localparam int REQ_W      = 2;
    localparam int STATUS_W   = 3;
    localparam int PADDR_W    = 4;
    localparam int PDATA_W    = 32;
    localparam int REG_IDX_W  = 2;

    localparam logic [REQ_W-1:0] REQ_VAR   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_BLOCK = 2'd1;
    localparam logic [REQ_W-1:0] REQ_FREE  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOSPACE  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_MODEOFF  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_MISALIGN = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

    localparam logic [REG_IDX_W-1:0] REG_HEAP_START    = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_HEAP_END      = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_BLOCK_LOG2    = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_VARIABLE_MODE = 2'd3;

    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [FIELD_W-1:0] alloc_size;
        logic [FIELD_W-1:0] release_addr;
    } req_word_t;

    typedef struct packed {
        logic [FIELD_W-1:0]  granted_addr;
        logic [STATUS_W-1:0] status;
    } rsp_word_t;

    typedef struct packed {
        logic [FIELD_W-1:0] heap_start;
        logic [FIELD_W-1:0] heap_end;
        logic [LOG2_W-1:0]  block_log2;
        logic               variable_mode;
    } cfg_t;

    typedef struct packed {
        logic               load;
        logic [FIELD_W-1:0] value;
    } brk_load_t;

    typedef struct packed {
        logic               push;
        logic               pop;
        logic [FIELD_W-1:0] push_data;
    } q_ctrl_t;

    typedef struct packed {
        logic               nonempty;
        logic               full;
        logic [FIELD_W-1:0] head_data;
    } q_stat_t;

endpackage

FILE: design/bafq_regs.sv
`timescale 1ns / 1ps
module bafq_regs #(
    parameter int ADDR_BITS = bafq_pkg::DEF_ADDR_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bafq_pkg::PADDR_W-1:0]      paddr,
    input  logic [bafq_pkg::PDATA_W-1:0]      pwdata,
    output logic [bafq_pkg::PDATA_W-1:0]      prdata,
    output bafq_pkg::cfg_t                    cfg,
    output bafq_pkg::brk_load_t               brk_load
);

    localparam int MW = ((ADDR_BITS > bafq_pkg::FIELD_W) ? ADDR_BITS : bafq_pkg::FIELD_W) + 1;
    localparam logic [MW-1:0] FULL_MASK = (MW'(1) << ADDR_BITS) - MW'(1);
    localparam logic [bafq_pkg::FIELD_W-1:0] VAL_MASK = bafq_pkg::FIELD_W'(FULL_MASK);

    bafq_pkg::cfg_t                     cfg_reg;
    bafq_pkg::cfg_t                     cfg_next;
    logic                               wr_en;
    logic [bafq_pkg::REG_IDX_W-1:0]     reg_idx;
    logic [bafq_pkg::FIELD_W-1:0]       addr_val;

    assign wr_en    = psel && penable && pwrite;
    assign reg_idx  = paddr[bafq_pkg::REG_IDX_W+1:2];
    assign addr_val = pwdata & VAL_MASK;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                bafq_pkg::REG_HEAP_START:    cfg_next.heap_start    = addr_val;
                bafq_pkg::REG_HEAP_END:      cfg_next.heap_end      = addr_val;
                bafq_pkg::REG_BLOCK_LOG2:    cfg_next.block_log2    = pwdata[bafq_pkg::LOG2_W-1:0];
                bafq_pkg::REG_VARIABLE_MODE: cfg_next.variable_mode = pwdata[0];
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (reg_idx)
            bafq_pkg::REG_HEAP_START:    prdata = cfg_reg.heap_start;
            bafq_pkg::REG_HEAP_END:      prdata = cfg_reg.heap_end;
            bafq_pkg::REG_BLOCK_LOG2:
                prdata = {{(bafq_pkg::PDATA_W-bafq_pkg::LOG2_W){1'b0}}, cfg_reg.block_log2};
            bafq_pkg::REG_VARIABLE_MODE:
                prdata = {{(bafq_pkg::PDATA_W-1){1'b0}}, cfg_reg.variable_mode};
            default:                     prdata = '0;
        endcase
    end

    // Writing the heap start also reloads the break pointer.
    assign brk_load.load  = wr_en && (reg_idx == bafq_pkg::REG_HEAP_START);
    assign brk_load.value = addr_val;
    assign cfg            = cfg_reg;

endmodule

FILE: design/bafq_queue.sv
`timescale 1ns / 1ps
module bafq_queue #(
    parameter int FREE_DEPTH = bafq_pkg::DEF_FREE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  bafq_pkg::q_ctrl_t  ctrl,
    output bafq_pkg::q_stat_t  stat
);

    localparam int PTR_W = (FREE_DEPTH > 1) ? $clog2(FREE_DEPTH) : 1;
    localparam int CNT_W = $clog2(FREE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(FREE_DEPTH - 1);

    logic [bafq_pkg::FIELD_W-1:0] mem [FREE_DEPTH];
    logic [bafq_pkg::FIELD_W-1:0] rd_data_reg;
    logic [bafq_pkg::FIELD_W-1:0] fwd_data_reg;
    logic                         fwd_hit_reg;
    logic [PTR_W-1:0]             head_reg;
    logic [PTR_W-1:0]             head_next;
    logic [PTR_W-1:0]             tail_reg;
    logic [PTR_W-1:0]             tail_next;
    logic [CNT_W-1:0]             count_reg;
    logic [CNT_W-1:0]             count_next;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (ctrl.pop)
        begin
            head_next  = (head_reg == LAST_PTR) ? '0 : head_reg + PTR_W'(1);
            count_next = count_reg - CNT_W'(1);
        end
        else if (ctrl.push)
        begin
            tail_next  = (tail_reg == LAST_PTR) ? '0 : tail_reg + PTR_W'(1);
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            fwd_hit_reg <= 1'b0;
        end
        else
        begin
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            count_reg   <= count_next;
            fwd_hit_reg <= ctrl.push && (tail_reg == head_next);
        end
    end

    // The head entry is fetched every cycle at the pointer it will hold next,
    // so the oldest word is always ready. A write to that same entry in the
    // same cycle is not yet visible in the read, hence the bypass.
    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            mem[tail_reg] <= ctrl.push_data;
        end
        rd_data_reg  <= mem[head_next];
        fwd_data_reg <= ctrl.push_data;
    end

    assign stat.nonempty  = (count_reg != '0);
    assign stat.full      = (count_reg == CNT_W'(FREE_DEPTH));
    assign stat.head_data = fwd_hit_reg ? fwd_data_reg : rd_data_reg;

endmodule

FILE: design/bafq_exec.sv
`timescale 1ns / 1ps
module bafq_exec #(
    parameter int ADDR_BITS = bafq_pkg::DEF_ADDR_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  bafq_pkg::cfg_t        cfg,
    input  bafq_pkg::brk_load_t   brk_load,
    input  logic                  fire,
    input  bafq_pkg::req_word_t   word,
    input  bafq_pkg::q_stat_t     q_stat,
    output bafq_pkg::q_ctrl_t     q_ctrl,
    output bafq_pkg::rsp_word_t   result
);

    localparam int CW = ((ADDR_BITS > bafq_pkg::FIELD_W) ? ADDR_BITS : bafq_pkg::FIELD_W) + 2;
    localparam logic [CW-1:0] ADDR_MASK = (CW'(1) << ADDR_BITS) - CW'(1);
    localparam logic [bafq_pkg::FIELD_W-1:0] FAIL_ADDR = bafq_pkg::FIELD_W'(ADDR_MASK);

    logic [ADDR_BITS-1:0] break_reg;
    logic [ADDR_BITS-1:0] break_next;
    logic                 brk_upd;
    logic                 push;
    logic                 pop;
    logic [CW-1:0]        brk_w;
    logic [CW-1:0]        end_w;
    logic [CW-1:0]        low_w;
    logic [CW-1:0]        var_end;
    logic [CW-1:0]        round_sum;
    logic [CW-1:0]        aligned;
    logic [CW-1:0]        blk_end;
    logic                 var_ok;
    logic                 blk_ok;
    logic                 misaligned;

    always_comb
    begin
        brk_w     = CW'(break_reg);
        end_w     = CW'(cfg.heap_end);
        low_w     = (CW'(1) << cfg.block_log2) - CW'(1);
        var_end   = brk_w + CW'(word.alloc_size);
        // An empty request fits even when the break already lies above the top.
        var_ok    = (word.alloc_size == '0) || (var_end <= end_w);
        round_sum = brk_w + low_w;
        aligned   = round_sum & ~low_w;
        // Rounded break plus one block, folded into a single add.
        blk_end   = (brk_w + {low_w[CW-2:0], 1'b1}) & ~low_w;
        blk_ok    = (round_sum <= ADDR_MASK) && (blk_end <= end_w);
        misaligned = (word.release_addr & low_w[bafq_pkg::FIELD_W-1:0]) != '0;

        result.granted_addr = FAIL_ADDR;
        result.status       = bafq_pkg::ST_MODEOFF;
        break_next          = break_reg;
        brk_upd             = 1'b0;
        push                = 1'b0;
        pop                 = 1'b0;

        case (word.req_type)
            bafq_pkg::REQ_VAR:
            begin
                if (!cfg.variable_mode)
                begin
                    result.status = bafq_pkg::ST_MODEOFF;
                end
                else if (var_ok)
                begin
                    result.granted_addr = bafq_pkg::FIELD_W'(brk_w);
                    result.status       = bafq_pkg::ST_OK;
                    break_next          = ADDR_BITS'(var_end);
                    brk_upd             = 1'b1;
                end
                else
                begin
                    result.status = bafq_pkg::ST_NOSPACE;
                end
            end
            bafq_pkg::REQ_BLOCK:
            begin
                if (q_stat.nonempty)
                begin
                    result.granted_addr = q_stat.head_data;
                    result.status       = bafq_pkg::ST_OK;
                    pop                 = 1'b1;
                end
                else if (blk_ok)
                begin
                    result.granted_addr = bafq_pkg::FIELD_W'(aligned);
                    result.status       = bafq_pkg::ST_OK;
                    break_next          = ADDR_BITS'(blk_end);
                    brk_upd             = 1'b1;
                end
                else
                begin
                    result.status = bafq_pkg::ST_NOSPACE;
                end
            end
            bafq_pkg::REQ_FREE:
            begin
                result.granted_addr = '0;
                if (misaligned)
                begin
                    result.status = bafq_pkg::ST_MISALIGN;
                end
                else if (q_stat.full)
                begin
                    result.status = bafq_pkg::ST_FULL;
                end
                else
                begin
                    result.status = bafq_pkg::ST_OK;
                    push          = 1'b1;
                end
            end
            default:
            begin
                result.granted_addr = FAIL_ADDR;
                result.status       = bafq_pkg::ST_MODEOFF;
            end
        endcase
    end

    assign q_ctrl.push      = fire && push;
    assign q_ctrl.pop       = fire && pop;
    assign q_ctrl.push_data = word.release_addr & FAIL_ADDR;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            break_reg <= '0;
        end
        else if (brk_load.load)
        begin
            break_reg <= ADDR_BITS'(brk_load.value);
        end
        else if (fire && brk_upd)
        begin
            break_reg <= break_next;
        end
    end

endmodule

FILE: design/bump_and_free_queue_allocator.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake                Word
// request   in         req_valid / req_stall    req_word  (bafq_pkg::req_word_t)
// response  out        rsp_valid / rsp_stall    rsp_word  (bafq_pkg::rsp_word_t)
// config    in         APB psel/penable/pwrite  paddr, pwdata, prdata, pready
//
// One request is taken per cycle while req_stall is low; it waits in the execute stage
// register and its result is registered into the response word when it fires. The free queue
// memory is read every cycle at the next head pointer, so a block allocation never waits
// for the read port.
// Reset clears the break pointer, queue pointers and all configuration.
// A stalled response holds the execute stage, and the request channel stalls
// only while a request waits there behind it.
module bump_and_free_queue_allocator #(
    parameter int FREE_DEPTH = bafq_pkg::DEF_FREE_DEPTH,
    parameter int ADDR_BITS  = bafq_pkg::DEF_ADDR_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    output logic                             req_stall,
    input  bafq_pkg::req_word_t              req_word,
    output logic                             rsp_valid,
    input  logic                             rsp_stall,
    output bafq_pkg::rsp_word_t              rsp_word,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [bafq_pkg::PADDR_W-1:0]     paddr,
    input  logic [bafq_pkg::PDATA_W-1:0]     pwdata,
    output logic [bafq_pkg::PDATA_W-1:0]     prdata,
    output logic                             pready
);

    bafq_pkg::cfg_t        cfg;
    bafq_pkg::brk_load_t   brk_load;
    bafq_pkg::q_ctrl_t     q_ctrl;
    bafq_pkg::q_stat_t     q_stat;
    bafq_pkg::rsp_word_t   result;
    bafq_pkg::req_word_t   s1_word_reg;
    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    bafq_pkg::rsp_word_t   out_word_reg;
    logic                  slot_free;
    logic                  fire;
    logic                  take;

    assign pready    = 1'b1;
    assign slot_free = !out_valid_reg || !rsp_stall;
    assign fire      = s1_valid_reg && slot_free;
    assign req_stall = s1_valid_reg && !slot_free;
    assign take      = req_valid && !req_stall;

    always_comb
    begin
        s1_valid_next  = take ? 1'b1 : (fire ? 1'b0 : s1_valid_reg);
        out_valid_next = fire ? 1'b1 : (rsp_stall ? out_valid_reg : 1'b0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_word_reg <= req_word;
        end
        if (fire)
        begin
            out_word_reg <= result;
        end
    end

    bafq_regs #(
        .ADDR_BITS (ADDR_BITS)
    ) u_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .cfg      (cfg),
        .brk_load (brk_load)
    );

    bafq_queue #(
        .FREE_DEPTH (FREE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (q_ctrl),
        .stat  (q_stat)
    );

    bafq_exec #(
        .ADDR_BITS (ADDR_BITS)
    ) u_exec (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .brk_load (brk_load),
        .fire     (fire),
        .word     (s1_word_reg),
        .q_stat   (q_stat),
        .q_ctrl   (q_ctrl),
        .result   (result)
    );

    assign rsp_valid = out_valid_reg;
    assign rsp_word  = out_word_reg;

endmodule

FILE: design/bafq_checker.sv
`timescale 1ns / 1ps
module bafq_checker (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    input  logic                  req_stall,
    input  bafq_pkg::req_word_t   req_word,
    input  logic                  rsp_valid,
    input  logic                  rsp_stall,
    input  bafq_pkg::rsp_word_t   rsp_word
);

    logic req_take;

    assign req_take = req_valid && !req_stall;

    // A response word that is held back must stay put.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
        else $error("response word changed while stalled");

    // Requests are only held up by a stalled response.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> rsp_valid && rsp_stall)
        else $error("request stalled without a stalled response");

    // A fresh response must trace back to a request that was taken before it.
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rsp_valid) && $past(!req_take, 2) |-> !rsp_valid)
        else $error("response appeared without a request");

    // Frees that are refused still answer with a zero address.
    a_free_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_word.status == bafq_pkg::ST_MISALIGN
                      || rsp_word.status == bafq_pkg::ST_FULL)
        |-> rsp_word.granted_addr == '0)
        else $error("refused free returned a nonzero address");

endmodule

bind bump_and_free_queue_allocator bafq_checker u_bafq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_word  (req_word),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_word  (rsp_word)
);

FILE: verif/testbench.sv
`timescale 1ns / 1ps
module testbench;

    localparam int CLK_HALF         = 2;
    localparam int RESET_CYCLES     = 8;
    localparam int CYCLE_LIMIT      = 200000;
    localparam int FREE_SLOTS       = bafq_pkg::DEF_FREE_DEPTH;
    localparam int ROUND_ITEMS      = 40;
    localparam int ROUNDS_PER_PHASE = 4;
    localparam int HOLD_CYCLES      = 300;
    localparam int PRINT_LIMIT      = 50;
    localparam logic [bafq_pkg::REQ_W-1:0] REQ_UNKNOWN = 2'd3;

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          req_valid = 1'b0;
    logic                          req_stall;
    bafq_pkg::req_word_t           req_word  = '0;
    logic                          rsp_valid;
    logic                          rsp_stall = 1'b0;
    bafq_pkg::rsp_word_t           rsp_word;
    logic                          psel      = 1'b0;
    logic                          penable   = 1'b0;
    logic                          pwrite    = 1'b0;
    logic [bafq_pkg::PADDR_W-1:0]  paddr     = '0;
    logic [bafq_pkg::PDATA_W-1:0]  pwdata    = '0;
    logic [bafq_pkg::PDATA_W-1:0]  prdata;
    logic                          pready;

    // Shadow copy of the allocator's registers and state.
    logic [bafq_pkg::FIELD_W-1:0]  cfg_heap_start    = '0;
    logic [bafq_pkg::FIELD_W-1:0]  cfg_heap_end      = '0;
    logic [bafq_pkg::LOG2_W-1:0]   cfg_block_log2    = '0;
    logic                          cfg_variable_mode = 1'b0;
    logic [bafq_pkg::FIELD_W-1:0]  shadow_break      = '0;
    logic [bafq_pkg::FIELD_W-1:0]  free_list[$];

    bafq_pkg::rsp_word_t           pending_grants[$];

    int unsigned         send_idle_pct = 0;
    int unsigned         stall_pct     = 0;
    int                  long_hold     = 0;
    int                  cycles        = 0;
    int                  mismatches    = 0;
    int                  config_count  = 0;
    int                  type_count[4];
    int                  status_count[8];

    bump_and_free_queue_allocator DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_word  (req_word),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #CLK_HALF clk = ~clk;

    always @(posedge clk)
    begin
        cycles = cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timed out after %0d cycles with %0d words outstanding",
                     cycles, pending_grants.size());
            $display("FAIL");
            $finish;
        end
    end

    // The receiver either holds off for a long stretch or stalls at random.
    always @(negedge clk)
    begin
        if (long_hold > 0)
        begin
            rsp_stall <= 1'b1;
            long_hold = long_hold - 1;
        end
        else
        begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic report_mismatch(input string msg);
        if (mismatches < PRINT_LIMIT)
            $display("mismatch at cycle %0d: %s", cycles, msg);
        mismatches++;
    endtask

    function automatic logic [bafq_pkg::FIELD_W-1:0] room_above(
        input logic [bafq_pkg::FIELD_W-1:0] base);
        return (cfg_heap_end > base) ? cfg_heap_end - base : '0;
    endfunction

    function automatic bafq_pkg::rsp_word_t predict_grant(input bafq_pkg::req_word_t r);
        bafq_pkg::rsp_word_t          res;
        logic [bafq_pkg::FIELD_W:0]   blk;
        logic [bafq_pkg::FIELD_W:0]   aligned;
        logic [bafq_pkg::FIELD_W-1:0] align_mask;
        blk = {{bafq_pkg::FIELD_W{1'b0}}, 1'b1} << cfg_block_log2;
        align_mask = blk[bafq_pkg::FIELD_W-1:0] - 1'b1;
        res.granted_addr = '1;
        res.status = bafq_pkg::ST_MODEOFF;
        case (r.req_type)
            bafq_pkg::REQ_VAR:
            begin
                if (cfg_variable_mode)
                begin
                    if (room_above(shadow_break) >= r.alloc_size)
                    begin
                        res.granted_addr = shadow_break;
                        res.status = bafq_pkg::ST_OK;
                        shadow_break = shadow_break + r.alloc_size;
                    end
                    else
                    begin
                        res.status = bafq_pkg::ST_NOSPACE;
                    end
                end
            end
            bafq_pkg::REQ_BLOCK:
            begin
                if (free_list.size() != 0)
                begin
                    res.granted_addr = free_list.pop_front();
                    res.status = bafq_pkg::ST_OK;
                end
                else
                begin
                    res.status = bafq_pkg::ST_NOSPACE;
                    aligned = ({1'b0, shadow_break} + blk - 1'b1) & ~(blk - 1'b1);
                    // Rounding must not run past the top of the address space.
                    if ({1'b0, shadow_break} <= {1'b0, {bafq_pkg::FIELD_W{1'b1}}} - (blk - 1'b1) &&
                        {1'b0, room_above(aligned[bafq_pkg::FIELD_W-1:0])} >= blk)
                    begin
                        res.granted_addr = aligned[bafq_pkg::FIELD_W-1:0];
                        res.status = bafq_pkg::ST_OK;
                        shadow_break = aligned[bafq_pkg::FIELD_W-1:0]
                                       + blk[bafq_pkg::FIELD_W-1:0];
                    end
                end
            end
            bafq_pkg::REQ_FREE:
            begin
                res.granted_addr = '0;
                if ((r.release_addr & align_mask) != '0)
                    res.status = bafq_pkg::ST_MISALIGN;
                else if (free_list.size() >= FREE_SLOTS)
                    res.status = bafq_pkg::ST_FULL;
                else
                begin
                    free_list.push_back(r.release_addr);
                    res.status = bafq_pkg::ST_OK;
                end
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    task automatic check_grant(input bafq_pkg::rsp_word_t got);
        bafq_pkg::rsp_word_t want;
        if (pending_grants.size() == 0)
        begin
            report_mismatch($sformatf("response word %h arrived with none outstanding", got));
            return;
        end
        want = pending_grants.pop_front();
        if (!$isunknown(got.status))
            status_count[got.status]++;
        if (got.granted_addr !== want.granted_addr)
            report_mismatch($sformatf("granted_addr %h, wanted %h",
                                      got.granted_addr, want.granted_addr));
        if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, wanted %0d", got.status, want.status));
    endtask

    // Both handshakes are sampled on the rising edge; inputs only move on the falling one.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
                check_grant(rsp_word);
            if (req_valid && !req_stall)
            begin
                type_count[req_word.req_type]++;
                pending_grants.push_back(predict_grant(req_word));
            end
        end
    end

    function automatic void mirror_config(input logic [bafq_pkg::REG_IDX_W-1:0] idx,
                                          input logic [bafq_pkg::PDATA_W-1:0] value);
        case (idx)
            bafq_pkg::REG_HEAP_START:
            begin
                cfg_heap_start = value;
                shadow_break = value;
            end
            bafq_pkg::REG_HEAP_END:      cfg_heap_end = value;
            bafq_pkg::REG_BLOCK_LOG2:    cfg_block_log2 = value[bafq_pkg::LOG2_W-1:0];
            bafq_pkg::REG_VARIABLE_MODE: cfg_variable_mode = value[0];
            default:
            begin
            end
        endcase
    endfunction

    task automatic apb_write(input logic [bafq_pkg::REG_IDX_W-1:0] idx,
                             input logic [bafq_pkg::PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        mirror_config(idx, value);
    endtask

    task automatic apb_read(input logic [bafq_pkg::REG_IDX_W-1:0] idx,
                            output logic [bafq_pkg::PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        value = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    // Called on a falling edge. On return the word has been taken and the next
    // falling edge has come, so the caller either offers a new word or drops valid.
    task automatic send_req(input bafq_pkg::req_word_t w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req_word  <= w;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        while (pending_grants.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_config(input logic [bafq_pkg::FIELD_W-1:0] hs,
                              input logic [bafq_pkg::FIELD_W-1:0] he,
                              input logic [bafq_pkg::LOG2_W-1:0] lg, input logic vm);
        drain();
        apb_write(bafq_pkg::REG_HEAP_END, he);
        apb_write(bafq_pkg::REG_BLOCK_LOG2, bafq_pkg::PDATA_W'(lg));
        apb_write(bafq_pkg::REG_VARIABLE_MODE, bafq_pkg::PDATA_W'(vm));
        apb_write(bafq_pkg::REG_HEAP_START, hs);
        config_count++;
    endtask

    function automatic bafq_pkg::req_word_t make_req(input logic [bafq_pkg::REQ_W-1:0] kind,
                                                     input logic [bafq_pkg::FIELD_W-1:0] size,
                                                     input logic [bafq_pkg::FIELD_W-1:0] addr);
        bafq_pkg::req_word_t r;
        r.req_type = kind;
        r.alloc_size = size;
        r.release_addr = addr;
        return r;
    endfunction

    // Mostly sensible traffic inside the heap, with some noise in every field.
    function automatic bafq_pkg::req_word_t random_request(input bit free_heavy);
        bafq_pkg::req_word_t          r;
        int unsigned                  pick;
        int unsigned                  span;
        logic [bafq_pkg::FIELD_W-1:0] align_mask;
        align_mask = (32'd1 << cfg_block_log2) - 32'd1;
        span = (cfg_heap_end > cfg_heap_start) ? cfg_heap_end - cfg_heap_start : 4096;
        r.alloc_size = $urandom;
        r.release_addr = $urandom;
        pick = $urandom_range(99);
        if (pick < (free_heavy ? 15 : 40))
        begin
            r.req_type = bafq_pkg::REQ_VAR;
            if ($urandom_range(15) != 0)
                r.alloc_size = $urandom_range(0, 96);
        end
        else if (pick < (free_heavy ? 35 : 70))
        begin
            r.req_type = bafq_pkg::REQ_BLOCK;
        end
        else if (pick < 96)
        begin
            r.req_type = bafq_pkg::REQ_FREE;
            if ($urandom_range(9) != 0)
                r.release_addr = (cfg_heap_start + $urandom_range(0, span)) & ~align_mask;
        end
        else
        begin
            r.req_type = REQ_UNKNOWN;
        end
        return r;
    endfunction

    task automatic random_config();
        logic [bafq_pkg::FIELD_W-1:0] hs;
        logic [bafq_pkg::FIELD_W-1:0] he;
        logic [bafq_pkg::LOG2_W-1:0]  lg;
        case ($urandom_range(7))
            0:
            begin
                hs = '0;
                he = '1;
                lg = 5'd31;
            end
            1:
            begin
                hs = 32'hFFFF_FF00 | $urandom_range(0, 255);
                he = '1;
                lg = bafq_pkg::LOG2_W'($urandom_range(0, 8));
            end
            2:
            begin
                hs = $urandom;
                he = $urandom;
                lg = bafq_pkg::LOG2_W'($urandom_range(0, 31));
            end
            default:
            begin
                hs = $urandom_range(0, 32'h7FFF_0000);
                he = hs + $urandom_range(16, 2048);
                lg = bafq_pkg::LOG2_W'($urandom_range(0, 6));
            end
        endcase
        set_config(hs, he, lg, $urandom_range(4) != 0);
    endtask

    task automatic test_config_regs();
        logic [bafq_pkg::PDATA_W-1:0]   patterns[4] = '{32'hFFFF_FFFF, 32'h0,
                                                        32'hA5A5_5A5A, 32'h5A5A_A5A5};
        logic [bafq_pkg::PDATA_W-1:0]   got;
        logic [bafq_pkg::PDATA_W-1:0]   want;
        logic [bafq_pkg::REG_IDX_W-1:0] idx;
        foreach (patterns[p])
        begin
            for (int r = 0; r < 4; r++)
            begin
                idx = bafq_pkg::REG_IDX_W'(r);
                apb_write(idx, patterns[p]);
                apb_read(idx, got);
                case (idx)
                    bafq_pkg::REG_HEAP_START: want = cfg_heap_start;
                    bafq_pkg::REG_HEAP_END:   want = cfg_heap_end;
                    bafq_pkg::REG_BLOCK_LOG2: want = bafq_pkg::PDATA_W'(cfg_block_log2);
                    default:                  want = bafq_pkg::PDATA_W'(cfg_variable_mode);
                endcase
                if (got !== want)
                    report_mismatch($sformatf("register %0d reads %h, wanted %h",
                                              idx, got, want));
            end
        end
        config_count++;
    endtask

    task automatic test_directed_cases();
        send_idle_pct = 0;
        stall_pct = 0;
        set_config(32'h1000, 32'h1040, 5'd4, 1'b0);
        send_req(make_req(bafq_pkg::REQ_VAR, 32'd4, $urandom));
        send_req(make_req(REQ_UNKNOWN, $urandom, $urandom));
        // An aligned break is kept as it is.
        send_req(make_req(bafq_pkg::REQ_BLOCK, $urandom, $urandom));
        send_req(make_req(bafq_pkg::REQ_FREE, $urandom, 32'h1008));
        // A foreign address and a double free are both queued.
        send_req(make_req(bafq_pkg::REQ_FREE, $urandom, 32'hFFFF_FFF0));
        send_req(make_req(bafq_pkg::REQ_FREE, $urandom, 32'hFFFF_FFF0));
        send_req(make_req(bafq_pkg::REQ_BLOCK, $urandom, $urandom));
        send_req(make_req(bafq_pkg::REQ_BLOCK, $urandom, $urandom));
        drain();
        apb_write(bafq_pkg::REG_VARIABLE_MODE, bafq_pkg::PDATA_W'(1'b1));
        send_req(make_req(bafq_pkg::REQ_VAR, 32'd0, $urandom));
        send_req(make_req(bafq_pkg::REQ_VAR, 32'd3, $urandom));
        send_req(make_req(bafq_pkg::REQ_BLOCK, $urandom, $urandom));
        send_req(make_req(bafq_pkg::REQ_VAR, 32'hFFFF_FFFF, $urandom));
        send_req(make_req(bafq_pkg::REQ_VAR, 32'd16, $urandom));
        send_req(make_req(bafq_pkg::REQ_BLOCK, $urandom, $urandom));
        send_req(make_req(bafq_pkg::REQ_VAR, 32'd0, $urandom));
        // Break above the heap top: only an empty variable request succeeds.
        set_config(32'h3000, 32'h1000, 5'd4, 1'b1);
        send_req(make_req(bafq_pkg::REQ_VAR, 32'd0, $urandom));
        send_req(make_req(bafq_pkg::REQ_VAR, 32'd1, $urandom));
        send_req(make_req(bafq_pkg::REQ_BLOCK, $urandom, $urandom));
        // Rounding the break up would leave the address space.
        set_config(32'hFFFF_FFF1, 32'hFFFF_FFFF, 5'd4, 1'b1);
        send_req(make_req(bafq_pkg::REQ_BLOCK, $urandom, $urandom));
        send_req(make_req(bafq_pkg::REQ_VAR, 32'd14, $urandom));
        set_config(32'h0, 32'hFFFF_FFFF, 5'd31, 1'b1);
        send_req(make_req(bafq_pkg::REQ_BLOCK, $urandom, $urandom));
        send_req(make_req(bafq_pkg::REQ_BLOCK, $urandom, $urandom));
        send_req(make_req(bafq_pkg::REQ_FREE, $urandom, 32'h8000_0000));
        send_req(make_req(bafq_pkg::REQ_FREE, $urandom, 32'h4000_0000));
        send_req(make_req(bafq_pkg::REQ_BLOCK, $urandom, $urandom));
        set_config(32'h0, 32'h0, 5'd0, 1'b0);
        send_req(make_req(bafq_pkg::REQ_FREE, $urandom, 32'hFFFF_FFFF));
        drain();
    endtask

    task automatic test_free_queue_full();
        send_idle_pct = 20;
        stall_pct = 20;
        set_config(32'h100, 32'h1_0000, 5'd3, 1'b1);
        repeat (FREE_SLOTS + 2)
            send_req(make_req(bafq_pkg::REQ_FREE, $urandom, $urandom & ~32'h7));
        // A misaligned address is refused before the full queue is considered.
        send_req(make_req(bafq_pkg::REQ_FREE, $urandom, 32'h13));
        repeat (FREE_SLOTS + 2)
            send_req(make_req(bafq_pkg::REQ_BLOCK, $urandom, $urandom));
        drain();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        stall_pct = 0;
        set_config(32'h0, 32'h4000, 5'd2, 1'b1);
        @(posedge clk);
        long_hold = HOLD_CYCLES;
        @(negedge clk);
        repeat (ROUND_ITEMS)
            send_req(random_request(1'b0));
        drain();
    endtask

    task automatic test_random_phases();
        int unsigned idle_pcts[4]  = '{0, 86, 0, 38};
        int unsigned stall_pcts[4] = '{0, 0, 86, 38};
        bit          heavy;
        for (int ph = 0; ph < 4; ph++)
        begin
            for (int rd = 0; rd < ROUNDS_PER_PHASE; rd++)
            begin
                random_config();
                send_idle_pct = idle_pcts[ph];
                stall_pct = stall_pcts[ph];
                heavy = ($urandom_range(3) == 0);
                repeat (ROUND_ITEMS)
                    send_req(random_request(heavy));
            end
        end
        drain();
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_config_regs();
        test_directed_cases();
        test_free_queue_full();
        test_backpressure();
        test_random_phases();
        drain();
        repeat (8) @(negedge clk);
        $display("Sent %0d requests (%0d variable, %0d block, %0d free, %0d unknown)",
                 type_count[0] + type_count[1] + type_count[2] + type_count[3],
                 type_count[bafq_pkg::REQ_VAR], type_count[bafq_pkg::REQ_BLOCK],
                 type_count[bafq_pkg::REQ_FREE], type_count[REQ_UNKNOWN]);
        $display("under %0d register settings; answers: %0d ok, %0d out of space, %0d mode off,",
                 config_count, status_count[bafq_pkg::ST_OK],
                 status_count[bafq_pkg::ST_NOSPACE], status_count[bafq_pkg::ST_MODEOFF]);
        $display("%0d misaligned, %0d queue full; %0d mismatches.",
                 status_count[bafq_pkg::ST_MISALIGN], status_count[bafq_pkg::ST_FULL],
                 mismatches);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: sim.f
design/bafq_pkg.sv
design/bafq_regs.sv
design/bafq_queue.sv
design/bafq_exec.sv
design/bump_and_free_queue_allocator.sv
design/bafq_checker.sv
verif/testbench.sv
